// ===== src/lsct_pkg.sv =====
// Shared types, widths and constants for the line sensor centroid tracker.
// No dependencies; every other file of the block imports this package.
package lsct_pkg;

    localparam int N_SENSORS = 8;
    localparam int WEIGHT_W  = 11;  // one sensor weight, 1/256 pitch, signed
    localparam int SUM_W     = 13;  // sum of the active weights, signed
    localparam int MAG_W     = 12;  // magnitude of that sum
    localparam int COUNT_W   = 4;   // 0..8 active sensors
    localparam int LOST_W    = 16;
    localparam int DIR_W     = 2;
    localparam int STEP_W    = $clog2(MAG_W + 1);

    localparam logic [LOST_W-1:0] LOST_MAX = {LOST_W{1'b1}};

    localparam logic signed [DIR_W-1:0] DIR_LEFT  = -2'sd1;
    localparam logic signed [DIR_W-1:0] DIR_NONE  = 2'sd0;
    localparam logic signed [DIR_W-1:0] DIR_RIGHT = 2'sd1;

    typedef logic signed [WEIGHT_W-1:0] t_weight;
    typedef logic signed [SUM_W-1:0]    t_sum;

    // Sensor pitch offsets from -3.5 to +3.5, leftmost sensor first.
    localparam t_weight WEIGHT_Q8 [N_SENSORS] = '{
        -11'sd896, -11'sd640, -11'sd384, -11'sd128,
        11'sd128, 11'sd384, 11'sd640, 11'sd896
    };

endpackage

// ===== src/line_sensor_centroid_tracker_top.sv =====
// Top level of the line sensor centroid tracker: lanes, merge stage, divider, control.
// Depends on lsct_pkg, lsct_lane, lsct_merge and lsct_div.
//
// One snapshot of eight sensor levels goes in per request and one result comes out.
// A snapshot passes through its acceptance, the lanes and the summing stage, the load of
// the divider, the one-bit-per-cycle restoring divider that forms the mean position and
// the load of the output register, which waits until that register is free, before the
// next snapshot can be accepted. The output register holds a result
// until the downstream side takes it while the next snapshot is already being worked
// on. active_low is written through i_cfg_we and i_cfg_wdata and should only change
// while no snapshot is in flight.
module line_sensor_centroid_tracker_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_wdata,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [lsct_pkg::N_SENSORS-1:0]      i_sensor_levels,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [lsct_pkg::N_SENSORS-1:0]      o_active_mask,
    output logic [lsct_pkg::COUNT_W-1:0]        o_active_count,
    output logic                                o_has_line,
    output logic signed [lsct_pkg::WEIGHT_W-1:0] o_raw_position,
    output logic [lsct_pkg::LOST_W-1:0]         o_lost_frames,
    output logic signed [lsct_pkg::DIR_W-1:0]   o_last_direction
);
    import lsct_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SUM,
        S_START,
        S_DIV
    } t_state;

    t_state                    r_state;
    logic                      r_active_low;
    logic [N_SENSORS-1:0]      r_levels;
    logic [LOST_W-1:0]         r_lost;
    logic signed [DIR_W-1:0]   r_dir;

    logic [N_SENSORS-1:0]      lane_active;
    t_weight                   lane_weight [N_SENSORS];
    logic [COUNT_W-1:0]        sum_count;
    t_sum                      sum_total;
    logic                      div_busy;
    logic [MAG_W-1:0]          div_quo;
    logic [MAG_W-1:0]          sum_mag;
    logic [MAG_W-1:0]          pos_full;
    logic signed [17:0]        sum_x10;
    logic signed [17:0]        thresh;
    logic                      seen;
    logic                      out_free;
    logic                      load_out;
    logic [LOST_W-1:0]         n_lost;
    logic signed [DIR_W-1:0]   n_dir;

    for (genvar g = 0; g < N_SENSORS; g++) begin : g_lane
        lsct_lane u_lane (
            .i_level      (r_levels[g]),
            .i_active_low (r_active_low),
            .i_weight     (WEIGHT_Q8[g]),
            .o_active     (lane_active[g]),
            .o_weight     (lane_weight[g])
        );
    end

    lsct_merge u_merge (
        .i_clk    (i_clk),
        .i_en     (r_state == S_SUM),
        .i_active (lane_active),
        .i_weight (lane_weight),
        .o_count  (sum_count),
        .o_sum    (sum_total)
    );

    assign sum_mag = sum_total[SUM_W-1] ? MAG_W'(-sum_total) : MAG_W'(sum_total);

    lsct_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_START),
        .i_dividend (sum_mag),
        .i_divisor  (sum_count),
        .o_busy     (div_busy),
        .o_quotient (div_quo)
    );

    assign seen     = sum_count != '0;
    assign pos_full = sum_total[SUM_W-1] ? (~div_quo + 1'b1) : div_quo;
    assign o_stall  = r_state != S_IDLE;
    assign out_free = !o_valid || !i_stall;
    assign load_out = (r_state == S_DIV) && !div_busy && out_free;

    // The direction test compares 10*sum with 128*count, so no rounding enters it.
    assign sum_x10 = 18'(sum_total) * 18'sd10;
    assign thresh  = $signed({7'b0, sum_count, 7'b0});

    always_comb begin
        n_lost = r_lost;
        n_dir  = r_dir;
        if (seen) begin
            n_lost = '0;
            if (sum_x10 > thresh) begin
                n_dir = DIR_RIGHT;
            end else if (sum_x10 < -thresh) begin
                n_dir = DIR_LEFT;
            end
        end else if (r_lost != LOST_MAX) begin
            n_lost = r_lost + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_low <= 1'b0;
        end else if (i_cfg_we) begin
            r_active_low <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lost  <= '0;
            r_dir   <= DIR_NONE;
            o_valid <= 1'b0;
        end else begin
            if (load_out) begin
                o_valid <= 1'b1;
            end else if (o_valid && !i_stall) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_levels <= i_sensor_levels;
                        r_state  <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_state <= S_START;
                end
                S_START: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (load_out) begin
                        o_active_mask    <= lane_active;
                        o_active_count   <= sum_count;
                        o_has_line       <= seen;
                        o_raw_position   <= seen ? $signed(pos_full[WEIGHT_W-1:0])
                                                 : t_weight'(0);
                        o_lost_frames    <= n_lost;
                        o_last_direction <= n_dir;
                        r_lost           <= n_lost;
                        r_dir            <= n_dir;
                        r_state          <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_count_matches_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_active_count == COUNT_W'($countones(o_active_mask)))
        else $error("active count disagrees with mask");

    a_no_line_zero_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_has_line) |-> o_raw_position == t_weight'(0))
        else $error("position not zero without a line");

    a_line_clears_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_has_line) |-> o_lost_frames == '0)
        else $error("lost count not cleared on a seen line");

    a_div_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_START |=> div_busy)
        else $error("divider did not start");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_raw_position <= 11'sd896 && o_raw_position >= -11'sd896))
        else $error("position out of range");

endmodule

// ===== src/lsct_lane.sv =====
// One sensor lane: polarity correction and the lane's weight contribution.
// Depends on lsct_pkg.
module lsct_lane (
    input  logic             i_level,
    input  logic             i_active_low,
    input  lsct_pkg::t_weight i_weight,
    output logic             o_active,
    output lsct_pkg::t_weight o_weight
);
    import lsct_pkg::*;

    assign o_active = i_level ^ i_active_low;
    assign o_weight = o_active ? i_weight : t_weight'(0);

endmodule

// ===== src/lsct_merge.sv =====
// Merging stage: registered count and weight sum over all lanes.
// Depends on lsct_pkg.
module lsct_merge (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [lsct_pkg::N_SENSORS-1:0] i_active,
    input  lsct_pkg::t_weight              i_weight [lsct_pkg::N_SENSORS],
    output logic [lsct_pkg::COUNT_W-1:0]   o_count,
    output lsct_pkg::t_sum                 o_sum
);
    import lsct_pkg::*;

    logic [COUNT_W-1:0] n_count;
    t_sum               n_sum;
    logic [COUNT_W-1:0] r_count;
    t_sum               r_sum;

    always_comb begin
        n_count = '0;
        n_sum   = '0;
        for (int i = 0; i < N_SENSORS; i++) begin
            n_count = n_count + COUNT_W'(i_active[i]);
            n_sum   = n_sum + t_sum'(i_weight[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_count <= n_count;
            r_sum   <= n_sum;
        end
    end

    assign o_count = r_count;
    assign o_sum   = r_sum;

endmodule

// ===== src/lsct_div.sv =====
// Restoring divider, one quotient bit per cycle, for the sum magnitude by the count.
// Depends on lsct_pkg.
module lsct_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [lsct_pkg::MAG_W-1:0]   i_dividend,
    input  logic [lsct_pkg::COUNT_W-1:0] i_divisor,
    output logic                         o_busy,
    output logic [lsct_pkg::MAG_W-1:0]   o_quotient
);
    import lsct_pkg::*;

    logic [STEP_W-1:0]  r_steps;
    logic [COUNT_W-1:0] r_divisor;
    logic [COUNT_W-1:0] r_rem;
    logic [MAG_W-1:0]   r_quo;
    logic [COUNT_W:0]   trial;
    logic               fits;

    // Remainder stays below a nonzero divisor, so it fits in COUNT_W bits.
    assign trial = {r_rem, r_quo[MAG_W-1]};
    assign fits  = trial >= {1'b0, r_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps <= '0;
        end else if (i_start) begin
            r_steps <= STEP_W'(MAG_W);
        end else if (r_steps != '0) begin
            r_steps <= r_steps - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_divisor <= i_divisor;
            r_rem     <= '0;
            r_quo     <= i_dividend;
        end else if (r_steps != '0) begin
            r_rem <= fits ? COUNT_W'(trial - {1'b0, r_divisor}) : trial[COUNT_W-1:0];
            r_quo <= {r_quo[MAG_W-2:0], fits};
        end
    end

    assign o_busy     = r_steps != '0;
    assign o_quotient = r_quo;

endmodule
